>>> hw/rtl/adsrg_pkg.sv
// ----------------------------------------------------------------------------
// adsrg_pkg - shared types and constants of the ADSR envelope gain block
// Phase codes, register indexes, widths and the beat structs that travel
// between the time cells, the operand stages and the divider cells.
// ----------------------------------------------------------------------------
package adsrg_pkg;

   localparam int TIME_BITS  = 24;
   localparam int HOLD_W     = 31;
   localparam int GAIN_W     = 16;
   localparam int NUM_W      = TIME_BITS + GAIN_W;
   localparam int CSR_DATA_W = (TIME_BITS > GAIN_W) ? TIME_BITS : GAIN_W;
   localparam int DIV_STEPS  = GAIN_W;
   localparam int STEP_W     = 4;
   localparam int NUM_TCELLS = 4;

   localparam logic [GAIN_W-1:0] ONE_Q15 = 16'h8000;

   typedef enum logic [2:0] {
      PH_BEFORE  = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      CSR_ATTACK  = 2'd0,
      CSR_DECAY   = 2'd1,
      CSR_SUSTAIN = 2'd2,
      CSR_RELEASE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic              decided;
      phase_type         phase;
      logic [HOLD_W-1:0] t;
      logic [HOLD_W-1:0] hold;
   } time_beat_type;

   typedef struct packed {
      logic                 valid;
      phase_type            phase;
      logic [NUM_W-1:0]     rem;
      logic [GAIN_W-1:0]    quo;
      logic [TIME_BITS-1:0] dvs;
   } div_beat_type;

endpackage

>>> hw/rtl/adsr_envelope_gain.sv
// ----------------------------------------------------------------------------
// adsr_envelope_gain - linear ADSR envelope gain
// Gain in Q1.15 and phase code for a time since note start, built from a row
// of phase cells, an operand and a multiply stage and a row of divider cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  elapsed, note_length
//  rsp      out        rsp_valid/rsp_ready  gain, phase
//  csr      in         csr_valid/csr_ready  index, data (always ready)
//
//  one beat per cycle unless stalled; stages: 4 phase cells, operand select,
//  multiply, 16 divider cells (one quotient bit each) and the output register
//  the whole pipeline holds while a result waits in the output register
//  reset clears the valid bits and sets the configuration registers to their reset values
// ----------------------------------------------------------------------------
module adsr_envelope_gain (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [31:0]                       req_elapsed,
   input  logic [adsrg_pkg::HOLD_W-1:0]      req_note_length,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [adsrg_pkg::GAIN_W-1:0]      rsp_gain,
   output logic [2:0]                        rsp_phase,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [adsrg_pkg::CSR_DATA_W-1:0]  csr_data
);
   import adsrg_pkg::*;

   logic [TIME_BITS-1:0] attack_ff;
   logic [TIME_BITS-1:0] decay_ff;
   logic [GAIN_W-1:0]    sustain_ff;
   logic [TIME_BITS-1:0] release_ff;
   logic [GAIN_W-1:0]    s_clamp;

   logic                 advance;

   time_beat_type        tc_beat [0:NUM_TCELLS];
   logic [HOLD_W-1:0]    cell_len [0:NUM_TCELLS-1];
   phase_type            cell_code [0:NUM_TCELLS-1];

   logic                 op_valid_ff;
   phase_type            op_phase_ff;
   logic [GAIN_W-1:0]    op_a_ff;
   logic [TIME_BITS-1:0] op_b_ff;
   logic [TIME_BITS-1:0] op_d_ff;
   phase_type            op_phase_in;
   logic [GAIN_W-1:0]    op_a_in;
   logic [TIME_BITS-1:0] op_b_in;
   logic [TIME_BITS-1:0] op_d_in;
   logic [TIME_BITS-1:0] t_short;

   div_beat_type         dc_beat [0:DIV_STEPS];
   div_beat_type         mul_ff;
   div_beat_type         mul_in;

   logic                 rsp_valid_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [GAIN_W-1:0]    gain_in;
   phase_type            phase_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= '0;
         decay_ff   <= '0;
         sustain_ff <= ONE_Q15;
         release_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ATTACK:  attack_ff  <= csr_data[TIME_BITS-1:0];
            CSR_DECAY:   decay_ff   <= csr_data[TIME_BITS-1:0];
            CSR_SUSTAIN: sustain_ff <= csr_data[GAIN_W-1:0];
            CSR_RELEASE: release_ff <= csr_data[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign s_clamp = (sustain_ff > ONE_Q15) ? ONE_Q15 : sustain_ff;

   // one global stall: everything moves unless a result is held
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // phase cells
   always_comb begin
      tc_beat[0].valid   = req_valid;
      tc_beat[0].decided = req_elapsed[31];
      tc_beat[0].phase   = PH_BEFORE;
      tc_beat[0].t       = req_elapsed[HOLD_W-1:0];
      tc_beat[0].hold    = req_note_length;
   end

   assign cell_len[0]  = HOLD_W'(attack_ff);
   assign cell_len[1]  = HOLD_W'(decay_ff);
   assign cell_len[2]  = tc_beat[2].hold;
   assign cell_len[3]  = HOLD_W'(release_ff);
   assign cell_code[0] = PH_ATTACK;
   assign cell_code[1] = PH_DECAY;
   assign cell_code[2] = PH_SUSTAIN;
   assign cell_code[3] = PH_RELEASE;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_TCELLS; gi++) begin : g_tcell
         adsrg_time_cell u_tcell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .len     (cell_len[gi]),
            .code    (cell_code[gi]),
            .beat_i  (tc_beat[gi]),
            .beat_o  (tc_beat[gi+1])
         );
      end
   endgenerate

   // operand select; t is below the phase length here, so it fits TIME_BITS
   assign t_short = tc_beat[NUM_TCELLS].t[TIME_BITS-1:0];

   always_comb begin
      op_phase_in = tc_beat[NUM_TCELLS].decided ? tc_beat[NUM_TCELLS].phase : PH_DONE;
      op_a_in     = '0;
      op_b_in     = '0;
      op_d_in     = '0;
      case (op_phase_in)
         PH_ATTACK: begin
            op_a_in = ONE_Q15;
            op_b_in = t_short;
            op_d_in = attack_ff;
         end
         PH_DECAY: begin
            op_a_in = ONE_Q15 - s_clamp;
            op_b_in = t_short;
            op_d_in = decay_ff;
         end
         PH_RELEASE: begin
            op_a_in = s_clamp;
            op_b_in = release_ff - t_short;
            op_d_in = release_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else if (advance) begin
         op_valid_ff <= tc_beat[NUM_TCELLS].valid;
         op_phase_ff <= op_phase_in;
         op_a_ff     <= op_a_in;
         op_b_ff     <= op_b_in;
         op_d_ff     <= op_d_in;
      end
   end

   // multiply into the dividend
   always_comb begin
      mul_in.valid = op_valid_ff;
      mul_in.phase = op_phase_ff;
      mul_in.rem   = NUM_W'(op_a_ff) * NUM_W'(op_b_ff);
      mul_in.quo   = '0;
      mul_in.dvs   = op_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
      end else if (advance) begin
         mul_ff <= mul_in;
      end
   end

   // divider cells, msb of the quotient first
   assign dc_beat[0] = mul_ff;

   generate
      for (gi = 0; gi < DIV_STEPS; gi++) begin : g_dcell
         adsrg_div_cell u_dcell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .step    (STEP_W'(DIV_STEPS - 1 - gi)),
            .beat_i  (dc_beat[gi]),
            .beat_o  (dc_beat[gi+1])
         );
      end
   endgenerate

   // gain from the quotient
   always_comb begin
      case (dc_beat[DIV_STEPS].phase)
         PH_ATTACK:  gain_in = dc_beat[DIV_STEPS].quo;
         PH_DECAY:   gain_in = ONE_Q15 - dc_beat[DIV_STEPS].quo;
         PH_SUSTAIN: gain_in = s_clamp;
         PH_RELEASE: gain_in = dc_beat[DIV_STEPS].quo;
         default:    gain_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dc_beat[DIV_STEPS].valid;
         gain_ff      <= gain_in;
         phase_ff     <= dc_beat[DIV_STEPS].phase;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_gain  = gain_ff;
   assign rsp_phase = phase_ff;

   // checks
   a_gain_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain <= ONE_Q15)
      else $error("gain above one");

   a_gain_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PH_BEFORE || rsp_phase == PH_DONE) |-> rsp_gain == '0)
      else $error("nonzero gain outside the envelope");

   a_sustain : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_SUSTAIN |-> rsp_gain == s_clamp)
      else $error("sustain gain differs from sustain level");

   // equal only when the sustain level is one
   a_decay : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_DECAY |-> rsp_gain >= s_clamp)
      else $error("decay gain below sustain level");

endmodule

>>> hw/rtl/adsrg_time_cell.sv
// ----------------------------------------------------------------------------
// adsrg_time_cell - one phase of the envelope timeline
// Decides whether the time falls inside this phase; if not, the phase length
// is taken off the time and the beat moves on to the next cell.
// ----------------------------------------------------------------------------
module adsrg_time_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [adsrg_pkg::HOLD_W-1:0]  len,
   input  adsrg_pkg::phase_type          code,
   input  adsrg_pkg::time_beat_type      beat_i,
   output adsrg_pkg::time_beat_type      beat_o
);
   import adsrg_pkg::*;

   time_beat_type beat_ff;
   time_beat_type beat_in;

   always_comb begin
      beat_in = beat_i;
      if (!beat_i.decided) begin
         // a zero length never matches, so that phase is skipped
         if (beat_i.t < len) begin
            beat_in.decided = 1'b1;
            beat_in.phase   = code;
         end else begin
            beat_in.t = beat_i.t - len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

>>> hw/rtl/adsrg_div_cell.sv
// ----------------------------------------------------------------------------
// adsrg_div_cell - one restoring division step
// Tries the divisor shifted by this cell's step against the remainder and
// sets that quotient bit when it fits.
// ----------------------------------------------------------------------------
module adsrg_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [adsrg_pkg::STEP_W-1:0]  step,
   input  adsrg_pkg::div_beat_type       beat_i,
   output adsrg_pkg::div_beat_type       beat_o
);
   import adsrg_pkg::*;

   div_beat_type     beat_ff;
   div_beat_type     beat_in;
   logic [NUM_W-1:0] trial;

   always_comb begin
      beat_in = beat_i;
      trial   = NUM_W'(beat_i.dvs) << step;
      if (beat_i.rem >= trial) begin
         beat_in.rem       = beat_i.rem - trial;
         beat_in.quo[step] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - ADSR envelope gain
// Drives elapsed time and note length beats through the envelope block under
// several register settings. Each accepted beat is predicted and each result
// is compared against it. Random idling and stalls are used on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import adsrg_pkg::*;

   localparam int LATENCY = 23;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam longint unsigned MAX_ELAPSED = 64'h7FFF_FFFF;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      phase_type         phase;
   } envelope_point_type;

   class envelope_tracker;
      logic [TIME_BITS-1:0] attack_len;
      logic [TIME_BITS-1:0] decay_len;
      logic [GAIN_W-1:0]    sustain_word;
      logic [TIME_BITS-1:0] release_len;
      envelope_point_type   points[$];
      int unsigned          failures;

      function new();
         attack_len   = '0;
         decay_len    = '0;
         sustain_word = ONE_Q15;
         release_len  = '0;
         failures     = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ATTACK:  attack_len = data[TIME_BITS-1:0];
            CSR_DECAY:   decay_len = data[TIME_BITS-1:0];
            CSR_SUSTAIN: sustain_word = data[GAIN_W-1:0];
            CSR_RELEASE: release_len = data[TIME_BITS-1:0];
            default: ;
         endcase
      endfunction

      function envelope_point_type envelope_at(logic [31:0] elapsed, logic [HOLD_W-1:0] hold);
         envelope_point_type pt;
         longint unsigned t, a, d, h, r, s, one;
         one = 64'(ONE_Q15);
         a = 64'(attack_len);
         d = 64'(decay_len);
         h = 64'(hold);
         r = 64'(release_len);
         s = (sustain_word > ONE_Q15) ? one : 64'(sustain_word);
         pt.gain  = '0;
         pt.phase = PH_BEFORE;
         if (!elapsed[31]) begin
            t = 64'(elapsed);
            if (t < a) begin
               pt.gain  = GAIN_W'((t * one) / a);
               pt.phase = PH_ATTACK;
            end else if (t - a < d) begin
               pt.gain  = GAIN_W'(one - ((one - s) * (t - a)) / d);
               pt.phase = PH_DECAY;
            end else if (t - a - d < h) begin
               pt.gain  = GAIN_W'(s);
               pt.phase = PH_SUSTAIN;
            end else if (t - a - d - h < r) begin
               pt.gain  = GAIN_W'((s * (r - (t - a - d - h))) / r);
               pt.phase = PH_RELEASE;
            end else begin
               pt.phase = PH_DONE;
            end
         end
         return pt;
      endfunction

      function void note_request(logic [31:0] elapsed, logic [HOLD_W-1:0] hold);
         points.push_back(envelope_at(elapsed, hold));
      endfunction

      function void check_response(logic [GAIN_W-1:0] gain, logic [2:0] phase);
         envelope_point_type want;
         if (points.size() == 0) begin
            $error("unexpected result beat: gain %0d phase %0d", gain, phase);
            failures++;
            return;
         end
         want = points.pop_front();
         if (gain !== want.gain) begin
            $error("gain: expected %0d, actual %0d", want.gain, gain);
            failures++;
         end
         if (phase !== 3'(want.phase)) begin
            $error("phase: expected %0d, actual %0d", want.phase, phase);
            failures++;
         end
      endfunction

      function int pending();
         return points.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [31:0]           req_elapsed;
   logic [HOLD_W-1:0]     req_note_length;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [GAIN_W-1:0]     rsp_gain;
   logic [2:0]            rsp_phase;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   envelope_tracker env = new();
   bit              sender_lazy = 1'b1;
   int unsigned     cycles = 0;

   adsr_envelope_gain dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_elapsed     (req_elapsed),
      .req_note_length (req_note_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_gain        (rsp_gain),
      .rsp_phase       (rsp_phase),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // both channels are sampled before any update of this edge lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) env.note_request(req_elapsed, req_note_length);
         if (rsp_valid && rsp_ready) env.check_response(rsp_gain, rsp_phase);
      end
   end

   initial begin : receiver
      int unsigned stall;
      int unsigned beats;
      bit          lazy;
      beats = 0;
      lazy  = 1'b1;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            beats++;
            if (beats % 100 == 0) lazy = ($urandom_range(0, 3) != 0);
            stall = lazy ? $urandom_range(0, 19) : 0;
            // long hold-off so the pipeline fills and backs up the input
            if (beats == 150 || beats == 1000) stall = 400;
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_beat(logic [31:0] e, logic [HOLD_W-1:0] h);
      int unsigned gap;
      gap = sender_lazy ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_elapsed     <= e;
      req_note_length <= h;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      env.set_reg(idx, data);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (env.pending() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic longint unsigned pick_between(longint unsigned lo, longint unsigned hi);
      longint unsigned span;
      span = hi - lo + 1;
      return lo + ({$urandom, $urandom} % span);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_length();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CSR_DATA_W'($urandom_range(1, 16));
         2: return CSR_DATA_W'($urandom_range(17, 4096));
         3: return CSR_DATA_W'($urandom_range(1, 1 << 20));
         4: return CSR_DATA_W'($urandom);
         default: return {CSR_DATA_W{1'b1}};
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_sustain();
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);   // bits above the gain width are dropped
      case ($urandom_range(0, 4))
         0: word[GAIN_W-1:0] = '0;
         1: word[GAIN_W-1:0] = ONE_Q15;
         2: word[GAIN_W-1:0] = GAIN_W'($urandom_range(32769, 65535));
         default: word[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 32768));
      endcase
      return word;
   endfunction

   function automatic logic [HOLD_W-1:0] pick_hold();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return HOLD_W'($urandom_range(1, 64));
         2: return HOLD_W'($urandom_range(65, 1 << 20));
         3: return HOLD_W'($urandom);
         default: return HOLD_W'($urandom_range(1, 4096));
      endcase
   endfunction

   // elapsed time aimed into one envelope segment, often right at its edges
   function automatic logic [31:0] aim_elapsed(logic [HOLD_W-1:0] hold);
      longint unsigned bound[5];
      longint unsigned lo, hi;
      phase_type aim;
      bound[0] = 0;
      bound[1] = 64'(env.attack_len);
      bound[2] = bound[1] + 64'(env.decay_len);
      bound[3] = bound[2] + 64'(hold);
      bound[4] = bound[3] + 64'(env.release_len);
      aim = phase_type'($urandom_range(0, 5));
      case (aim)
         PH_BEFORE: return {1'b1, 31'($urandom)};
         PH_ATTACK: begin
            lo = bound[0];
            hi = bound[1];
         end
         PH_DECAY: begin
            lo = bound[1];
            hi = bound[2];
         end
         PH_SUSTAIN: begin
            lo = bound[2];
            hi = bound[3];
         end
         PH_RELEASE: begin
            lo = bound[3];
            hi = bound[4];
         end
         default: begin
            lo = bound[4];
            hi = bound[4] + 1000;
         end
      endcase
      if (lo >= hi || lo > MAX_ELAPSED) return {1'b0, 31'($urandom)};
      if (hi > MAX_ELAPSED + 1) hi = MAX_ELAPSED + 1;
      case ($urandom_range(0, 3))
         0: return 32'(lo);
         1: return 32'(hi - 1);
         default: return 32'(pick_between(lo, hi - 1));
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0]       e;
      logic [HOLD_W-1:0] h;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_elapsed     <= '0;
      req_note_length <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_ATTACK;
      csr_data        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: attack, decay and release have zero length
      send_beat(32'd0, 31'd0);
      send_beat(32'd7, 31'd0);
      send_beat(32'd7, 31'd20);
      send_beat(32'hFFFF_FFFF, 31'd20);
      settle();

      write_reg(CSR_ATTACK, CSR_DATA_W'(100));
      write_reg(CSR_DECAY, CSR_DATA_W'(200));
      write_reg(CSR_SUSTAIN, CSR_DATA_W'(16384));
      write_reg(CSR_RELEASE, CSR_DATA_W'(300));
      csr_valid <= 1'b0;
      // segment edges with a hold of 1000
      send_beat(32'd0, 31'd1000);
      send_beat(32'd1, 31'd1000);
      send_beat(32'd99, 31'd1000);
      send_beat(32'd100, 31'd1000);
      send_beat(32'd101, 31'd1000);
      send_beat(32'd299, 31'd1000);
      send_beat(32'd300, 31'd1000);
      send_beat(32'd1299, 31'd1000);
      send_beat(32'd1300, 31'd1000);
      send_beat(32'd1301, 31'd1000);
      send_beat(32'd1599, 31'd1000);
      send_beat(32'd1600, 31'd1000);
      send_beat(32'h7FFF_FFFF, 31'd1000);
      send_beat(32'h8000_0000, 31'd1000);
      send_beat(32'hFFFF_FFFF, 31'd1000);
      // no hold: decay runs straight into release; then the largest time and hold
      send_beat(32'd300, 31'd0);
      send_beat(32'd450, 31'd0);
      send_beat(32'h7FFF_FFFF, 31'h7FFF_FFFF);

      for (int p = 0; p < 8; p++) begin
         settle();
         case (p)
            0: begin
               write_reg(CSR_ATTACK, {CSR_DATA_W{1'b1}});
               write_reg(CSR_DECAY, {CSR_DATA_W{1'b1}});
               write_reg(CSR_SUSTAIN, CSR_DATA_W'(ONE_Q15));
               write_reg(CSR_RELEASE, {CSR_DATA_W{1'b1}});
            end
            1: begin
               write_reg(CSR_ATTACK, '0);
               write_reg(CSR_DECAY, '0);
               write_reg(CSR_SUSTAIN, '0);
               write_reg(CSR_RELEASE, '0);
            end
            2: begin
               // sustain above one is clamped
               write_reg(CSR_ATTACK, CSR_DATA_W'($urandom_range(1, 16)));
               write_reg(CSR_DECAY, CSR_DATA_W'($urandom_range(1, 16)));
               write_reg(CSR_SUSTAIN, CSR_DATA_W'(16'hFFFF));
               write_reg(CSR_RELEASE, CSR_DATA_W'($urandom_range(1, 16)));
            end
            default: begin
               write_reg(CSR_ATTACK, pick_length());
               write_reg(CSR_DECAY, pick_length());
               write_reg(CSR_SUSTAIN, pick_sustain());
               write_reg(CSR_RELEASE, pick_length());
            end
         endcase
         csr_valid <= 1'b0;
         for (int k = 0; k < 225; k++) begin
            if (k % 50 == 0) sender_lazy = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 15) begin
               e = $urandom;
               h = HOLD_W'($urandom);
            end else begin
               h = pick_hold();
               e = aim_elapsed(h);
            end
            send_beat(e, h);
         end
      end

      settle();
      if (env.failures == 0 && env.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> adsr_envelope_gain.f
hw/rtl/adsrg_pkg.sv
hw/rtl/adsrg_time_cell.sv
hw/rtl/adsrg_div_cell.sv
hw/rtl/adsr_envelope_gain.sv
tb/sv/testbench.sv
